/* design/ijac_pkg.sv */
// Shared types, constants and helpers for the isoparametric Jacobian block.
// Used by every module under design/; depends on nothing.
`default_nettype none

package ijac_pkg;

    typedef enum logic
    {
        KIND_TRI  = 1'b0,
        KIND_QUAD = 1'b1
    } kind_t;

    localparam kind_t KIND_RESET = KIND_QUAD;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // quotient bits resolved by the divider lanes, one per stage
    localparam int QBITS    = 31;
    localparam int AXIS_LAT = 3;
    localparam int CART_LAT = 3;
    localparam int LANES    = 8;
    localparam int LAT      = AXIS_LAT + CART_LAT + QBITS + 1;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed
    {
        logic signed [31:0] s_coord;
        logic signed [31:0] t_coord;
        logic signed [31:0] node0_x;
        logic signed [31:0] node0_y;
        logic signed [31:0] node1_x;
        logic signed [31:0] node1_y;
        logic signed [31:0] node2_x;
        logic signed [31:0] node2_y;
        logic signed [31:0] node3_x;
        logic signed [31:0] node3_y;
    } item_t;

    typedef struct packed
    {
        logic signed [31:0] dndx_node0;
        logic signed [31:0] dndx_node1;
        logic signed [31:0] dndx_node2;
        logic signed [31:0] dndx_node3;
        logic signed [31:0] dndy_node0;
        logic signed [31:0] dndy_node1;
        logic signed [31:0] dndy_node2;
        logic signed [31:0] dndy_node3;
        logic signed [63:0] jacobian_det;
        logic               status;
        logic signed [31:0] mapped_x;
        logic signed [31:0] mapped_y;
    } result_t;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = SAT_MAX;
        else if (v < -40'sd2147483648)
            r = SAT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/isoparametric_jacobian_2d.sv */
// Isoparametric Jacobian for a 2D triangle or quad element, streaming.
// Depends on ijac_pkg, ijac_axis, ijac_cart and ijac_divider.
`default_nettype none

// The block takes one point every cycle unless the result side stalls, and
// passes it through these register stages: three form the Jacobian and
// mapped point, three more the determinant and derivative numerators, 31
// divider stages resolve one quotient bit each for the eight Cartesian
// derivatives, and one output register holds the result. A stall on the
// result side freezes the whole pipeline and holds the input side off with
// it. element_kind (reset: quad) is written through the cfg port and must
// only change while the pipeline is empty.
module isoparametric_jacobian_2d
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire ijac_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output ijac_pkg::result_t      result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_data
);
    import ijac_pkg::*;

    localparam int MAP_DLY = CART_LAT + QBITS;

    kind_t          kind_reg;
    logic [LAT-1:0] vpipe_reg;
    logic           en;

    assign en           = !(vpipe_reg[LAT - 1] && result_stall);
    assign item_stall   = !en;
    assign result_valid = vpipe_reg[LAT - 1];
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_RESET;
            vpipe_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                kind_reg <= kind_t'(cfg_data);
            if (en)
                vpipe_reg <= {vpipe_reg[LAT-2:0], item_valid};
        end
    end

    // Jacobian columns and mapped point
    logic signed [31:0] j00, j10, j01, j11, mx, my;

    ijac_axis u_axis_x
    (
        .clk  (clk),
        .en   (en),
        .kind (kind_reg),
        .c0   (item.node0_x),
        .c1   (item.node1_x),
        .c2   (item.node2_x),
        .c3   (item.node3_x),
        .s    (item.s_coord),
        .t    (item.t_coord),
        .ds   (j00),
        .dt   (j10),
        .m    (mx)
    );

    ijac_axis u_axis_y
    (
        .clk  (clk),
        .en   (en),
        .kind (kind_reg),
        .c0   (item.node0_y),
        .c1   (item.node1_y),
        .c2   (item.node2_y),
        .c3   (item.node3_y),
        .s    (item.s_coord),
        .t    (item.t_coord),
        .ds   (j01),
        .dt   (j11),
        .m    (my)
    );

    // align s, t and kind with the axis outputs
    kind_t              kind_dly_reg [AXIS_LAT];
    logic signed [31:0] s_dly_reg    [AXIS_LAT];
    logic signed [31:0] t_dly_reg    [AXIS_LAT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_dly_reg[0] <= kind_reg;
            s_dly_reg[0]    <= item.s_coord;
            t_dly_reg[0]    <= item.t_coord;
            for (int i = 1; i < AXIS_LAT; i++)
            begin
                kind_dly_reg[i] <= kind_dly_reg[i - 1];
                s_dly_reg[i]    <= s_dly_reg[i - 1];
                t_dly_reg[i]    <= t_dly_reg[i - 1];
            end
        end
    end

    logic [LANES-1:0][65:0] mag;
    logic [LANES-1:0]       neg, ovf;
    logic signed [63:0]     det;
    logic                   bad;

    ijac_cart u_cart
    (
        .clk  (clk),
        .en   (en),
        .kind (kind_dly_reg[AXIS_LAT - 1]),
        .s    (s_dly_reg[AXIS_LAT - 1]),
        .t    (t_dly_reg[AXIS_LAT - 1]),
        .j00  (j00),
        .j01  (j01),
        .j10  (j10),
        .j11  (j11),
        .mag  (mag),
        .neg  (neg),
        .ovf  (ovf),
        .det  (det),
        .bad  (bad)
    );

    logic [LANES-1:0][QBITS-1:0] quo;
    logic [LANES-1:0]            neg_q, ovf_q;

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        ijac_divider u_div
        (
            .clk     (clk),
            .en      (en),
            .mag     (mag[g]),
            .den     (det[62:0]),
            .neg_in  (neg[g]),
            .ovf_in  (ovf[g]),
            .quo     (quo[g]),
            .neg_out (neg_q[g]),
            .ovf_out (ovf_q[g])
        );
    end

    // carry mapped point, determinant and status alongside the dividers
    logic signed [31:0] mx_dly_reg  [MAP_DLY];
    logic signed [31:0] my_dly_reg  [MAP_DLY];
    logic signed [63:0] det_dly_reg [QBITS];
    logic               bad_dly_reg [QBITS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx_dly_reg[0]  <= mx;
            my_dly_reg[0]  <= my;
            det_dly_reg[0] <= det;
            bad_dly_reg[0] <= bad;
            for (int i = 1; i < MAP_DLY; i++)
            begin
                mx_dly_reg[i] <= mx_dly_reg[i - 1];
                my_dly_reg[i] <= my_dly_reg[i - 1];
            end
            for (int i = 1; i < QBITS; i++)
            begin
                det_dly_reg[i] <= det_dly_reg[i - 1];
                bad_dly_reg[i] <= bad_dly_reg[i - 1];
            end
        end
    end

    // saturate, sign and zero on a bad determinant
    logic signed [31:0] deriv [LANES];
    logic               bad_out;
    result_t            result_next, result_reg;

    assign bad_out = bad_dly_reg[QBITS - 1];

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (bad_out)
                deriv[i] = '0;
            else if (neg_q[i])
                deriv[i] = ovf_q[i] ? SAT_MIN : 32'(33'sd0 - 33'({2'b0, quo[i]}));
            else
                deriv[i] = ovf_q[i] ? SAT_MAX : 32'({1'b0, quo[i]});
        end
        result_next.dndx_node0   = deriv[0];
        result_next.dndx_node1   = deriv[1];
        result_next.dndx_node2   = deriv[2];
        result_next.dndx_node3   = deriv[3];
        result_next.dndy_node0   = deriv[4];
        result_next.dndy_node1   = deriv[5];
        result_next.dndy_node2   = deriv[6];
        result_next.dndy_node3   = deriv[7];
        result_next.jacobian_det = det_dly_reg[QBITS - 1];
        result_next.status       = bad_out ? STATUS_BAD : STATUS_OK;
        result_next.mapped_x     = mx_dly_reg[MAP_DLY - 1];
        result_next.mapped_y     = my_dly_reg[MAP_DLY - 1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

/* design/ijac_axis.sv */
// One physical axis: Jacobian column (d/ds, d/dt) and mapped coordinate.
// Three register stages; uses ijac_pkg.
`default_nettype none

module ijac_axis
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire ijac_pkg::kind_t      kind,
    input  wire logic signed [31:0]   c0,
    input  wire logic signed [31:0]   c1,
    input  wire logic signed [31:0]   c2,
    input  wire logic signed [31:0]   c3,
    input  wire logic signed [31:0]   s,
    input  wire logic signed [31:0]   t,
    output logic signed [31:0]        ds,
    output logic signed [31:0]        dt,
    output logic signed [31:0]        m
);
    import ijac_pkg::*;

    // stage 1: node combinations and the reduced s*t
    logic signed [33:0] c0w, c1w, c2w, c3w;
    logic signed [33:0] sum_next, as_next, at_next, bb_next, st_next;
    logic signed [63:0] st_prod, st_sh;

    kind_t              kind1_reg;
    logic signed [31:0] s1_reg, t1_reg;
    logic signed [33:0] sum1_reg, as1_reg, at1_reg, bb1_reg, st1_reg;

    assign c0w = 34'(c0);
    assign c1w = 34'(c1);
    assign c2w = 34'(c2);
    assign c3w = 34'(c3);
    assign st_prod = s * t;
    assign st_sh   = st_prod >>> 30;
    assign st_next = st_sh[33:0];

    always_comb
    begin
        if (kind == KIND_QUAD)
        begin
            sum_next = c0w + c1w + c2w + c3w;
            as_next  = -c0w + c1w + c2w - c3w;
            at_next  = -c0w - c1w + c2w + c3w;
            bb_next  = c0w - c1w + c2w - c3w;
        end
        else
        begin
            sum_next = c0w;
            as_next  = c1w - c0w;
            at_next  = c2w - c0w;
            bb_next  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind1_reg <= kind;
            s1_reg    <= s;
            t1_reg    <= t;
            sum1_reg  <= sum_next;
            as1_reg   <= as_next;
            at1_reg   <= at_next;
            bb1_reg   <= bb_next;
            st1_reg   <= st_next;
        end
    end

    // stage 2: products, floored to Q.30
    logic signed [65:0] p_s, p_t, p_bt, p_bs;
    logic signed [67:0] p_bst;
    logic signed [65:0] p_s_sh, p_t_sh, p_bt_sh, p_bs_sh;
    logic signed [67:0] p_bst_sh;

    kind_t              kind2_reg;
    logic signed [33:0] sum2_reg, as2_reg, at2_reg;
    logic signed [35:0] ps2_reg, pt2_reg, pbt2_reg, pbs2_reg;
    logic signed [36:0] pbst2_reg;

    assign p_s   = as1_reg * s1_reg;
    assign p_t   = at1_reg * t1_reg;
    assign p_bt  = bb1_reg * t1_reg;
    assign p_bs  = bb1_reg * s1_reg;
    assign p_bst = bb1_reg * st1_reg;
    assign p_s_sh   = p_s >>> 30;
    assign p_t_sh   = p_t >>> 30;
    assign p_bt_sh  = p_bt >>> 30;
    assign p_bs_sh  = p_bs >>> 30;
    assign p_bst_sh = p_bst >>> 30;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind2_reg <= kind1_reg;
            sum2_reg  <= sum1_reg;
            as2_reg   <= as1_reg;
            at2_reg   <= at1_reg;
            ps2_reg   <= p_s_sh[35:0];
            pt2_reg   <= p_t_sh[35:0];
            pbt2_reg  <= p_bt_sh[35:0];
            pbs2_reg  <= p_bs_sh[35:0];
            pbst2_reg <= p_bst_sh[36:0];
        end
    end

    // stage 3: sum, quarter for quads, saturate
    logic signed [39:0] ds_w, dt_w, m_w, ds_q, dt_q, m_q;
    logic signed [31:0] ds_next, dt_next, m_next;
    logic signed [31:0] ds_reg, dt_reg, m_reg;

    always_comb
    begin
        if (kind2_reg == KIND_QUAD)
        begin
            ds_w = 40'(as2_reg) + 40'(pbt2_reg);
            dt_w = 40'(at2_reg) + 40'(pbs2_reg);
            m_w  = 40'(sum2_reg) + 40'(ps2_reg) + 40'(pt2_reg) + 40'(pbst2_reg);
            ds_q = ds_w >>> 2;
            dt_q = dt_w >>> 2;
            m_q  = m_w >>> 2;
        end
        else
        begin
            ds_w = 40'(as2_reg);
            dt_w = 40'(at2_reg);
            m_w  = 40'(sum2_reg) + 40'(ps2_reg) + 40'(pt2_reg);
            ds_q = ds_w;
            dt_q = dt_w;
            m_q  = m_w;
        end
        ds_next = sat32(ds_q);
        dt_next = sat32(dt_q);
        m_next  = sat32(m_q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ds_reg <= ds_next;
            dt_reg <= dt_next;
            m_reg  <= m_next;
        end
    end

    assign ds = ds_reg;
    assign dt = dt_reg;
    assign m  = m_reg;

endmodule

`default_nettype wire

/* design/ijac_cart.sv */
// Determinant and cofactor numerators of the Cartesian derivatives.
// Three register stages feeding the divider lanes; uses ijac_pkg.
`default_nettype none

module ijac_cart
(
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire ijac_pkg::kind_t            kind,
    input  wire logic signed [31:0]         s,
    input  wire logic signed [31:0]         t,
    input  wire logic signed [31:0]         j00,
    input  wire logic signed [31:0]         j01,
    input  wire logic signed [31:0]         j10,
    input  wire logic signed [31:0]         j11,
    output logic [ijac_pkg::LANES-1:0][65:0] mag,
    output logic [ijac_pkg::LANES-1:0]       neg,
    output logic [ijac_pkg::LANES-1:0]       ovf,
    output logic signed [63:0]              det,
    output logic                            bad
);
    import ijac_pkg::*;

    localparam logic signed [33:0] ONE = 34'sh1_0000_0000;
    localparam logic signed [33:0] QTR = 34'sh0_4000_0000;

    // stage 4: natural derivatives and all products
    logic signed [33:0] sw, tw;
    logic signed [33:0] dns [4];
    logic signed [33:0] dnt [4];
    logic signed [32:0] j00w, j11w, nj01, nj10;
    logic signed [66:0] pa_next [LANES];
    logic signed [66:0] pb_next [LANES];
    logic signed [63:0] pd0_next, pd1_next;

    logic signed [65:0] pa_reg [LANES];
    logic signed [65:0] pb_reg [LANES];
    logic signed [63:0] pd0_reg, pd1_reg;

    assign sw   = 34'(s);
    assign tw   = 34'(t);
    assign j00w = 33'(j00);
    assign j11w = 33'(j11);
    assign nj01 = -33'(j01);
    assign nj10 = -33'(j10);
    assign pd0_next = j00 * j11;
    assign pd1_next = j01 * j10;

    always_comb
    begin
        if (kind == KIND_QUAD)
        begin
            dns[0] = -QTR + tw;
            dns[1] = QTR - tw;
            dns[2] = QTR + tw;
            dns[3] = -QTR - tw;
            dnt[0] = -QTR + sw;
            dnt[1] = -QTR - sw;
            dnt[2] = QTR + sw;
            dnt[3] = QTR - sw;
        end
        else
        begin
            dns[0] = -ONE;
            dns[1] = ONE;
            dns[2] = '0;
            dns[3] = '0;
            dnt[0] = -ONE;
            dnt[1] = '0;
            dnt[2] = ONE;
            dnt[3] = '0;
        end
        for (int n = 0; n < 4; n++)
        begin
            pa_next[n]     = j11w * dns[n];
            pb_next[n]     = nj01 * dnt[n];
            pa_next[4 + n] = nj10 * dns[n];
            pb_next[4 + n] = j00w * dnt[n];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                pa_reg[i] <= pa_next[i][65:0];
                pb_reg[i] <= pb_next[i][65:0];
            end
            pd0_reg <= pd0_next;
            pd1_reg <= pd1_next;
        end
    end

    // stage 5: determinant and signed numerators
    logic signed [66:0] v5_reg [LANES];
    logic signed [63:0] det5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LANES; i++)
                v5_reg[i] <= 67'(pa_reg[i]) + 67'(pb_reg[i]);
            det5_reg <= pd0_reg - pd1_reg;
        end
    end

    // stage 6: magnitudes, and flag quotients at or above 2^31
    logic [66:0] abs_v [LANES];
    logic [LANES-1:0][65:0] mag_next;
    logic [LANES-1:0]       ovf_next;
    logic [LANES-1:0]       neg_next;
    logic [LANES-1:0][65:0] mag_reg;
    logic [LANES-1:0]       ovf_reg, neg_reg;
    logic signed [63:0]     det6_reg;
    logic                   bad_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            abs_v[i]    = v5_reg[i][66] ? 67'(-v5_reg[i]) : 67'(v5_reg[i]);
            mag_next[i] = abs_v[i][65:0];
            neg_next[i] = v5_reg[i][66];
            ovf_next[i] = {28'b0, abs_v[i][65:0]} >= {det5_reg[62:0], 31'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg  <= mag_next;
            ovf_reg  <= ovf_next;
            neg_reg  <= neg_next;
            det6_reg <= det5_reg;
            bad_reg  <= det5_reg[63] || (det5_reg == '0);
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;
    assign ovf = ovf_reg;
    assign det = det6_reg;
    assign bad = bad_reg;

endmodule

`default_nettype wire

/* design/ijac_divider.sv */
// Restoring divider lane, one quotient bit per register stage.
// Gives floor(mag / den) for quotients below 2^31; uses ijac_pkg.
`default_nettype none

module ijac_divider
(
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [65:0]                   mag,
    input  wire logic [62:0]                   den,
    input  wire logic                          neg_in,
    input  wire logic                          ovf_in,
    output logic [ijac_pkg::QBITS-1:0]         quo,
    output logic                               neg_out,
    output logic                               ovf_out
);
    import ijac_pkg::*;

    logic [65:0]      rem_reg [QBITS];
    logic [QBITS-1:0] q_reg   [QBITS];
    logic [62:0]      den_reg [QBITS];
    logic             neg_reg [QBITS];
    logic             ovf_reg [QBITS];

    logic [65:0]      rem_in  [QBITS];
    logic [QBITS-1:0] q_in    [QBITS];
    logic [62:0]      den_in  [QBITS];
    logic [94:0]      trial   [QBITS];

    always_comb
    begin
        for (int i = 0; i < QBITS; i++)
        begin
            if (i == 0)
            begin
                rem_in[i] = mag;
                q_in[i]   = '0;
                den_in[i] = den;
            end
            else
            begin
                rem_in[i] = rem_reg[i - 1];
                q_in[i]   = q_reg[i - 1];
                den_in[i] = den_reg[i - 1];
            end
            trial[i] = {29'b0, rem_in[i]} - ({32'b0, den_in[i]} << (QBITS - 1 - i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < QBITS; i++)
            begin
                // keep the difference when it did not go negative
                rem_reg[i] <= trial[i][94] ? rem_in[i] : trial[i][65:0];
                q_reg[i]   <= {q_in[i][QBITS-2:0], ~trial[i][94]};
                den_reg[i] <= den_in[i];
                neg_reg[i] <= (i == 0) ? neg_in : neg_reg[(i == 0) ? 0 : i - 1];
                ovf_reg[i] <= (i == 0) ? ovf_in : ovf_reg[(i == 0) ? 0 : i - 1];
            end
        end
    end

    assign quo     = q_reg[QBITS - 1];
    assign neg_out = neg_reg[QBITS - 1];
    assign ovf_out = ovf_reg[QBITS - 1];

endmodule

`default_nettype wire

/* bench/ijac_checker.sv */
// Checker for isoparametric_jacobian_2d: predicts one result word per point word
// and compares it with what the block returns. Depends on ijac_pkg only.
module ijac_checker
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    input  wire logic              item_stall,
    input  wire ijac_pkg::item_t   item,
    input  wire logic              result_valid,
    input  wire logic              result_stall,
    input  wire ijac_pkg::result_t result,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic              cfg_data,
    output int                     fails,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ijac_pkg::*;

    typedef logic signed [127:0] w_t;

    localparam w_t WMAX = 128'sd2147483647;
    localparam w_t WMIN = -128'sd2147483648;

    kind_t   kind;
    result_t expected_q[$];

    function automatic w_t clip32(w_t v);
        if (v > WMAX)
            return WMAX;
        if (v < WMIN)
            return WMIN;
        return v;
    endfunction

    // floor(b*v / 2^30)
    function automatic w_t mul_q30(w_t b, w_t v);
        w_t p;
        p = b * v;
        return p >>> 30;
    endfunction

    // Jacobian column (ds, dt) and mapped coordinate for one physical axis
    function automatic void axis_eval(input kind_t k, input w_t c0, c1, c2, c3,
                                      input w_t s, t, output w_t ds, dt, m);
        w_t sum, as_c, at_c, bb, st;
        if (k == KIND_TRI)
        begin
            ds = clip32(c1 - c0);
            dt = clip32(c2 - c0);
            m  = clip32(c0 + mul_q30(c1 - c0, s) + mul_q30(c2 - c0, t));
        end
        else
        begin
            sum  = c0 + c1 + c2 + c3;
            as_c = -c0 + c1 + c2 - c3;
            at_c = -c0 - c1 + c2 + c3;
            bb   = c0 - c1 + c2 - c3;
            st   = (s * t) >>> 30;
            ds = clip32((as_c + mul_q30(bb, t)) >>> 2);
            dt = clip32((at_c + mul_q30(bb, s)) >>> 2);
            m  = clip32((sum + mul_q30(as_c, s) + mul_q30(at_c, t) + mul_q30(bb, st)) >>> 2);
        end
    endfunction

    // (ja*da + jb*db) / det toward zero, saturated; det > 0
    function automatic logic signed [31:0] cart_deriv(w_t ja, da, jb, db, det);
        w_t num;
        logic [127:0] mag, q;
        num = ja * da + jb * db;
        mag = (num < 0) ? -num : num;
        q = mag / det;
        if (num < 0)
            return (q >= 128'd2147483648) ? SAT_MIN : -q[31:0];
        return (q > 128'd2147483647) ? SAT_MAX : q[31:0];
    endfunction

    function automatic result_t jacobian_of(item_t it, kind_t k);
        result_t r;
        w_t s, t, j00, j01, j10, j11, mx, my, det, qv;
        w_t dns[4], dnt[4];
        logic signed [31:0] dx[4], dy[4];
        logic bad;
        s = it.s_coord;
        t = it.t_coord;
        axis_eval(k, w_t'(it.node0_x), w_t'(it.node1_x), w_t'(it.node2_x),
                  w_t'(it.node3_x), s, t, j00, j10, mx);
        axis_eval(k, w_t'(it.node0_y), w_t'(it.node1_y), w_t'(it.node2_y),
                  w_t'(it.node3_y), s, t, j01, j11, my);
        det = j00 * j11 - j01 * j10;
        bad = (det <= 0);
        if (k == KIND_TRI)
        begin
            qv = 128'sd4294967296;
            dns[0] = -qv; dns[1] = qv; dns[2] = 0;  dns[3] = 0;
            dnt[0] = -qv; dnt[1] = 0;  dnt[2] = qv; dnt[3] = 0;
        end
        else
        begin
            qv = 128'sd1073741824;
            dns[0] = -qv + t; dns[1] = qv - t; dns[2] = qv + t; dns[3] = -qv - t;
            dnt[0] = -qv + s; dnt[1] = -qv - s; dnt[2] = qv + s; dnt[3] = qv - s;
        end
        for (int n = 0; n < 4; n++)
        begin
            dx[n] = bad ? 32'sd0 : cart_deriv(j11, dns[n], -j01, dnt[n], det);
            dy[n] = bad ? 32'sd0 : cart_deriv(-j10, dns[n], j00, dnt[n], det);
        end
        r.dndx_node0 = dx[0]; r.dndx_node1 = dx[1];
        r.dndx_node2 = dx[2]; r.dndx_node3 = dx[3];
        r.dndy_node0 = dy[0]; r.dndy_node1 = dy[1];
        r.dndy_node2 = dy[2]; r.dndy_node3 = dy[3];
        r.jacobian_det = det[63:0];
        r.status = bad ? STATUS_BAD : STATUS_OK;
        r.mapped_x = mx[31:0];
        r.mapped_y = my[31:0];
        return r;
    endfunction

    function automatic int field_diff(string name, logic [63:0] e, logic [63:0] a);
        if (e === a)
            return 0;
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, e, a);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        int bad;
        if (!rst_n)
        begin
            kind <= KIND_RESET;
            fails <= 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                kind <= kind_t'(cfg_data);
            if (item_valid && !item_stall)
                expected_q.push_back(jacobian_of(item, kind));
            if (result_valid && !result_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t ns: result word with nothing expected, actual %h",
                             $time, result);
                    fails <= fails + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    bad = 0;
                    bad += field_diff("dndx_node0", e.dndx_node0, result.dndx_node0);
                    bad += field_diff("dndx_node1", e.dndx_node1, result.dndx_node1);
                    bad += field_diff("dndx_node2", e.dndx_node2, result.dndx_node2);
                    bad += field_diff("dndx_node3", e.dndx_node3, result.dndx_node3);
                    bad += field_diff("dndy_node0", e.dndy_node0, result.dndy_node0);
                    bad += field_diff("dndy_node1", e.dndy_node1, result.dndy_node1);
                    bad += field_diff("dndy_node2", e.dndy_node2, result.dndy_node2);
                    bad += field_diff("dndy_node3", e.dndy_node3, result.dndy_node3);
                    bad += field_diff("jacobian_det", e.jacobian_det, result.jacobian_det);
                    bad += field_diff("status", e.status, result.status);
                    bad += field_diff("mapped_x", e.mapped_x, result.mapped_x);
                    bad += field_diff("mapped_y", e.mapped_y, result.mapped_y);
                    if (bad != 0)
                        fails <= fails + 1;
                end
            end
        end
    end

    assign pending = expected_q.size();

endmodule

/* bench/isoparametric_jacobian_2d_tb.sv */
// Top of the isoparametric_jacobian_2d bench: clock, reset, point and element
// stimulus, stalls and verdict. Depends on ijac_pkg, the block and ijac_checker.
module isoparametric_jacobian_2d_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ijac_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic    cfg_data = 1'b0;
    int      fails;
    int      pending;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    int      quiet_cycles = 0;

    always #4 clk = ~clk;

    isoparametric_jacobian_2d uut
    (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    ijac_checker chk
    (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fails(fails), .pending(pending)
    );

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("isoparametric_jacobian_2d_tb: FAIL");
            $finish;
        end
    end

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_point(item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (LAT + 4) @(negedge clk);
    endtask

    task automatic write_kind(kind_t k);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= k;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic item_t point_of(logic signed [31:0] s, t, x0, y0, x1, y1,
                                       x2, y2, x3, y3);
        item_t it;
        it.s_coord = s; it.t_coord = t;
        it.node0_x = x0; it.node0_y = y0; it.node1_x = x1; it.node1_y = y1;
        it.node2_x = x2; it.node2_y = y2; it.node3_x = x3; it.node3_y = y3;
        return it;
    endfunction

    task automatic directed_points();
        logic signed [31:0] u;
        u = ONE_Q16;
        // reference square, center and corners
        send_point(point_of(0, 0, -u, -u, u, -u, u, u, -u, u));
        send_point(point_of(ONE_Q30, ONE_Q30, -u, -u, u, -u, u, u, -u, u));
        send_point(point_of(-ONE_Q30, -ONE_Q30, 0, 0, u, 0, u, u, 0, u));
        send_point(point_of(ONE_Q30, -ONE_Q30, 0, 0, 3 * u, 0, 2 * u, 2 * u, 0, u));
        // outside the reference range
        send_point(point_of(SAT_MAX, SAT_MIN, 0, 0, u, 0, u, u, 0, u));
        send_point(point_of(SAT_MIN, SAT_MAX, -u, -u, u, -u, u, u, -u, u));
        // collapsed element: zero determinant
        send_point(point_of(0, 0, u, u, u, u, u, u, u, u));
        // inverted node order: negative determinant
        send_point(point_of(0, 0, -u, -u, -u, u, u, u, u, -u));
        // coordinate extremes, saturating sums
        send_point(point_of(ONE_Q30, 0, SAT_MIN, SAT_MIN, SAT_MAX, SAT_MIN,
                            SAT_MAX, SAT_MAX, SAT_MIN, SAT_MAX));
        send_point(point_of(SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX,
                            SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
        send_point(point_of(SAT_MAX, SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN,
                            SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX));
        // tiny element: triangle derivatives saturate; as a quad the determinant is zero
        send_point(point_of(0, 0, 0, 0, 1, 0, 1, 1, 0, 1));
        // node 3 garbage matters only for quads
        send_point(point_of(ONE_Q30 / 3, ONE_Q30 / 5, 0, 0, u, 0, 0, u, SAT_MIN, SAT_MAX));
    endtask

    function automatic item_t random_point();
        item_t it;
        int mode;
        int sh;
        logic signed [31:0] cx, cy, sc;
        mode = $urandom_range(99);
        if (mode < 15)
        begin
            it = {$urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, $urandom};
        end
        else
        begin
            // well-formed element: scaled square with jitter, point near range
            sh = $urandom_range(22);
            sc = 32'sd1 <<< (sh + 4);
            cx = $signed($urandom) >>> $urandom_range(31, 2);
            cy = $signed($urandom) >>> $urandom_range(31, 2);
            it.node0_x = cx - sc + ($signed($urandom) >>> (31 - sh));
            it.node0_y = cy - sc + ($signed($urandom) >>> (31 - sh));
            it.node1_x = cx + sc + ($signed($urandom) >>> (31 - sh));
            it.node1_y = cy - sc + ($signed($urandom) >>> (31 - sh));
            it.node2_x = cx + sc + ($signed($urandom) >>> (31 - sh));
            it.node2_y = cy + sc + ($signed($urandom) >>> (31 - sh));
            it.node3_x = cx - sc + ($signed($urandom) >>> (31 - sh));
            it.node3_y = cy + sc + ($signed($urandom) >>> (31 - sh));
            if (mode < 25)
            begin
                // mirror the element to flip the determinant sign
                it.node0_x = -it.node0_x; it.node1_x = -it.node1_x;
                it.node2_x = -it.node2_x; it.node3_x = -it.node3_x;
            end
            it.s_coord = $signed($urandom) >>> 1;
            it.t_coord = $signed($urandom) >>> 1;
        end
        return it;
    endfunction

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        directed_points();
        write_kind(KIND_TRI);
        directed_points();

        for (int blk = 0; blk < 6; blk++)
        begin
            if (blk < 2)
            begin
                send_idle_pct = 9;
                stall_pct = 76;
            end
            else if (blk < 4)
            begin
                send_idle_pct = 76;
                stall_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            write_kind((blk % 2 == 0) ? KIND_QUAD : KIND_TRI);
            for (int i = 0; i < 300; i++)
            begin
                send_point(random_point());
                // hold off once until the pipeline empties
                if (blk == 4 && i == 150)
                begin
                    item_valid <= 1'b0;
                    while (pending != 0)
                        @(negedge clk);
                end
            end
        end

        drain();
        if (fails == 0)
            $display("isoparametric_jacobian_2d_tb: PASS");
        else
            $display("isoparametric_jacobian_2d_tb: FAIL");
        $finish;
    end

endmodule

/* sim.f */
design/ijac_pkg.sv
design/ijac_axis.sv
design/ijac_cart.sv
design/ijac_divider.sv
design/isoparametric_jacobian_2d.sv
bench/ijac_checker.sv
bench/isoparametric_jacobian_2d_tb.sv
